>>> design/value_noise_3d_unit_macros.svh
// Assertion macros shared by the value noise unit.
`ifndef VALUE_NOISE_3D_UNIT_MACROS_SVH
`define VALUE_NOISE_3D_UNIT_MACROS_SVH

// check a property on every clock edge outside reset
`define VN3_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check a property on every clock edge, reset included
`define VN3_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/vn3_pkg.sv
// Types and constants of the value noise unit.
package vn3_pkg;

   localparam int WORD_W     = 32;
   localparam int VALUE_W    = 24;
   localparam int NUM_DIMS   = 3;
   localparam int NUM_CORNERS = 8;
   localparam int NUM_STAGES = 13;

   localparam logic [WORD_W-1:0] MIX_K1     = 32'h7feb352d;
   localparam logic [WORD_W-1:0] MIX_K2     = 32'h846ca68b;
   localparam logic [WORD_W-1:0] HASH_KX    = 32'h8da6b343;
   localparam logic [WORD_W-1:0] HASH_KY    = 32'hd8163841;
   localparam logic [WORD_W-1:0] HASH_KZ    = 32'hcb1ab31f;
   localparam logic [WORD_W-1:0] SALT_RESET = 32'h68bc21eb;

   localparam logic [NUM_DIMS-1:0][WORD_W-1:0] HASH_K = {HASH_KZ, HASH_KY, HASH_KX};

   typedef struct packed {
      logic mul_a;
      logic mul_b;
      logic mul_c;
      logic mul_d;
      logic value;
   } hash_en_type;

   typedef struct packed {
      logic product;
      logic sum;
   } lerp_en_type;

endpackage

>>> design/vn3_hash.sv
// One corner lane: double mix of the cell hash, down to a Q0.24 corner value.
module vn3_hash
   import vn3_pkg::*;
(
   input  logic               clock,
   input  hash_en_type        en,
   input  logic [WORD_W-1:0]  salt,
   input  logic [WORD_W-1:0]  hash_word,
   output logic [VALUE_W-1:0] value
);

   logic [WORD_W-1:0]  mul_a_ff, mul_b_ff, mul_c_ff, mul_d_ff;
   logic [WORD_W-1:0]  mul_a_in, mul_b_in, mul_c_in, mul_d_in;
   logic [WORD_W-1:0]  xa, xb, xc, xc_salt, xc_mix, xd, xe;
   logic [VALUE_W-1:0] value_ff, value_in;

   always_comb begin
      xa       = hash_word ^ (hash_word >> 16);
      mul_a_in = xa * MIX_K1;
      xb       = mul_a_ff ^ (mul_a_ff >> 15);
      mul_b_in = xb * MIX_K2;
      xc       = mul_b_ff ^ (mul_b_ff >> 16);
      xc_salt  = xc ^ salt;
      xc_mix   = xc_salt ^ (xc_salt >> 16);
      mul_c_in = xc_mix * MIX_K1;
      xd       = mul_c_ff ^ (mul_c_ff >> 15);
      mul_d_in = xd * MIX_K2;
      xe       = mul_d_ff ^ (mul_d_ff >> 16);
      value_in = xe[WORD_W-1:WORD_W-VALUE_W];
   end

   always_ff @(posedge clock) begin
      if (en.mul_a) begin
         mul_a_ff <= mul_a_in;
      end
      if (en.mul_b) begin
         mul_b_ff <= mul_b_in;
      end
      if (en.mul_c) begin
         mul_c_ff <= mul_c_in;
      end
      if (en.mul_d) begin
         mul_d_ff <= mul_d_in;
      end
      if (en.value) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

>>> design/vn3_lerp.sv
// Two-stage fixed-point lerp: signed product, then floor shift and add.
module vn3_lerp
   import vn3_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  lerp_en_type          en,
   input  logic [VALUE_W-1:0]   a,
   input  logic [VALUE_W-1:0]   b,
   input  logic [FRAC_BITS-1:0] t,
   output logic [VALUE_W-1:0]   y
);

   localparam int PROD_W = VALUE_W + FRAC_BITS + 2;

   logic signed [VALUE_W:0]   diff;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [PROD_W-1:0]  quot;
   logic [VALUE_W-1:0]        a_ff;
   logic [VALUE_W-1:0]        y_ff, y_in;

   always_comb begin
      diff    = $signed({1'b0, b}) - $signed({1'b0, a});
      prod_in = diff * $signed({1'b0, t});
      quot    = prod_ff >>> FRAC_BITS;
      y_in    = a_ff + quot[VALUE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en.product) begin
         prod_ff <= prod_in;
         a_ff    <= a;
      end
      if (en.sum) begin
         y_ff <= y_in;
      end
   end

   assign y = y_ff;

endmodule

>>> design/value_noise_3d_unit.sv
// Top level of the 3D value noise unit: pipeline control, cell hashing and interpolation.
//
// Usage:
//   req_ channel takes one point a word: three signed fixed-point coordinates with
//   FRAC_BITS fraction bits. rsp_ channel returns one Q0.24 noise value per point,
//   in order. csr_ channel writes the hash salt; write it only while the unit is empty.
//   Pipeline: 13 register stages from the accepting edge to rsp_valid, set by four
//   32-bit multiplies per corner lane and three two-stage lerps.
//   Throughput: one word per cycle while rsp_ready is high; every stage holds its
//   own valid bit and moves as soon as the stage after it is free, so bubbles close up.
//   Stall: while rsp_ready is low the result holds; earlier stages keep filling
//   and req_ready drops only once all 13 stages are full.
//   Reset: clears every valid bit and loads the salt with its default; csr_ready
//   is always high.
//   FRAC_BITS may range from 8 to 24.
//
`include "value_noise_3d_unit_macros.svh"
module value_noise_3d_unit
   import vn3_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [WORD_W-1:0]  req_x_coord,
   input  logic signed [WORD_W-1:0]  req_y_coord,
   input  logic signed [WORD_W-1:0]  req_z_coord,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [VALUE_W-1:0]        rsp_noise_value,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [WORD_W-1:0]         csr_hash_salt
);

   localparam logic [FRAC_BITS+1:0] THREE_ONE = (FRAC_BITS+2)'(3) << FRAC_BITS;

   logic [WORD_W-1:0]                       salt_ff;
   logic [NUM_STAGES-1:0]                   vld_ff, vld_in;
   logic [NUM_STAGES:0]                     en;

   logic [NUM_DIMS-1:0][WORD_W-1:0]         coord;
   logic [NUM_DIMS-1:0][WORD_W-1:0]         cell_idx;
   logic [NUM_DIMS-1:0][WORD_W-1:0]         prod_ff, prod_in;
   logic [NUM_DIMS-1:0][FRAC_BITS-1:0]      frac_ff, frac_in;
   logic [NUM_DIMS-1:0][2*FRAC_BITS-1:0]    sq_full;
   logic [NUM_DIMS-1:0][FRAC_BITS-1:0]      sq_ff, sq_in;

   logic [NUM_DIMS-1:0][FRAC_BITS+1:0]      factor;
   logic [NUM_DIMS-1:0][2*FRAC_BITS+1:0]    wt_full;
   logic [NUM_DIMS-1:0][FRAC_BITS-1:0]      wt_in;
   logic [NUM_DIMS-1:0][FRAC_BITS-1:0]      wt_ff [1:10];
   logic [NUM_DIMS-1:0][WORD_W-1:0]         upper;
   logic [NUM_CORNERS-1:0][WORD_W-1:0]      hash_ff, hash_in;

   logic [NUM_CORNERS-1:0][VALUE_W-1:0]     corner;
   logic [3:0][VALUE_W-1:0]                 along_x;
   logic [1:0][VALUE_W-1:0]                 along_y;
   logic [VALUE_W-1:0]                      along_z;

   hash_en_type                             hash_en;
   lerp_en_type                             x_en, y_en, z_en;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         salt_ff <= SALT_RESET;
      end else if (csr_valid && csr_ready) begin
         salt_ff <= csr_hash_salt;
      end
   end

   // stage handshake: a stage moves when empty or when its successor moves
   always_comb begin
      en[NUM_STAGES] = rsp_ready;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
      vld_in = vld_ff;
      if (en[0]) begin
         vld_in[0] = req_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (en[k]) begin
            vld_in[k] = vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = vld_ff[NUM_STAGES-1];

   // stage 0: cell products, fractions and squared fractions
   assign coord = {req_z_coord, req_y_coord, req_x_coord};

   always_comb begin
      for (int d = 0; d < NUM_DIMS; d++) begin
         cell_idx[d] = WORD_W'($signed(coord[d]) >>> FRAC_BITS);
         prod_in[d]  = cell_idx[d] * HASH_K[d];
         frac_in[d]  = coord[d][FRAC_BITS-1:0];
         sq_full[d]  = frac_in[d] * frac_in[d];
         sq_in[d]    = sq_full[d][2*FRAC_BITS-1:FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         prod_ff <= prod_in;
         frac_ff <= frac_in;
         sq_ff   <= sq_in;
      end
   end

   // stage 1: corner hash words and smoothstep weights
   always_comb begin
      for (int d = 0; d < NUM_DIMS; d++) begin
         factor[d]  = THREE_ONE - (FRAC_BITS+2)'({frac_ff[d], 1'b0});
         wt_full[d] = sq_ff[d] * factor[d];
         wt_in[d]   = wt_full[d][2*FRAC_BITS-1:FRAC_BITS];
         upper[d]   = prod_ff[d] + HASH_K[d];
      end
      for (int k = 0; k < NUM_CORNERS; k++) begin
         hash_in[k] = (((k & 1) != 0) ? upper[0] : prod_ff[0])
                    ^ (((k & 2) != 0) ? upper[1] : prod_ff[1])
                    ^ (((k & 4) != 0) ? upper[2] : prod_ff[2]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         hash_ff  <= hash_in;
         wt_ff[1] <= wt_in;
      end
      for (int k = 2; k <= 10; k++) begin
         if (en[k]) begin
            wt_ff[k] <= wt_ff[k-1];
         end
      end
   end

   // stages 2 to 6: corner lanes
   assign hash_en = '{mul_a: en[2], mul_b: en[3], mul_c: en[4], mul_d: en[5], value: en[6]};

   for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_corner
      vn3_hash u_hash (
         .clock     (clock),
         .en        (hash_en),
         .salt      (salt_ff),
         .hash_word (hash_ff[k]),
         .value     (corner[k])
      );
   end

   // stages 7 to 12: interpolate along x, then y, then z
   assign x_en = '{product: en[7], sum: en[8]};
   assign y_en = '{product: en[9], sum: en[10]};
   assign z_en = '{product: en[11], sum: en[12]};

   for (genvar j = 0; j < 4; j++) begin : g_lerp_x
      vn3_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp (
         .clock (clock),
         .en    (x_en),
         .a     (corner[2*j]),
         .b     (corner[2*j+1]),
         .t     (wt_ff[6][0]),
         .y     (along_x[j])
      );
   end

   for (genvar j = 0; j < 2; j++) begin : g_lerp_y
      vn3_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp (
         .clock (clock),
         .en    (y_en),
         .a     (along_x[2*j]),
         .b     (along_x[2*j+1]),
         .t     (wt_ff[8][1]),
         .y     (along_y[j])
      );
   end

   vn3_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_z (
      .clock (clock),
      .en    (z_en),
      .a     (along_y[0]),
      .b     (along_y[1]),
      .t     (wt_ff[10][2]),
      .y     (along_z)
   );

   assign rsp_noise_value = along_z;

   // checks
   `VN3_ASSERT_ALWAYS(a_salt_reset, clock, reset |=> (salt_ff == SALT_RESET), "salt not restored by reset")
   `VN3_ASSERT(a_full_when_blocked, clock, reset, !req_ready |-> (&vld_ff), "input blocked with a free stage")
   `VN3_ASSERT(a_occupancy, clock, reset, !$past(reset) |-> ($countones(vld_ff) + int'($past(rsp_valid && rsp_ready)) == $countones($past(vld_ff)) + int'($past(req_valid && req_ready))), "word lost or duplicated in the pipeline")

endmodule

>>> sim/tb_value_noise_3d_unit.sv
// Self-checking testbench for the value noise unit: directed and random points against a predictor.
`timescale 1ns / 100ps

module tb_value_noise_3d_unit;
   import vn3_pkg::*;

   localparam int FRAC_BITS     = 16;
   localparam int SETTLE_CYCLES = 16;

   localparam logic [31:0] SCRAMBLE_M1  = 32'h7feb352d;
   localparam logic [31:0] SCRAMBLE_M2  = 32'h846ca68b;
   localparam logic [31:0] CELL_MUL_X   = 32'h8da6b343;
   localparam logic [31:0] CELL_MUL_Y   = 32'hd8163841;
   localparam logic [31:0] CELL_MUL_Z   = 32'hcb1ab31f;
   localparam logic [31:0] DEFAULT_SALT = 32'h68bc21eb;

   typedef enum int {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_NEVER} ready_mode_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic signed [WORD_W-1:0] req_x_coord = '0;
   logic signed [WORD_W-1:0] req_y_coord = '0;
   logic signed [WORD_W-1:0] req_z_coord = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [VALUE_W-1:0]       rsp_noise_value;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [WORD_W-1:0]        csr_hash_salt = '0;

   logic [WORD_W-1:0]  salt_shadow = DEFAULT_SALT;
   logic [VALUE_W-1:0] expected_noise[$];
   logic [VALUE_W-1:0] noise_want;
   int                 errors = 0;
   int                 points_sent = 0;
   int                 salt_writes = 0;
   int                 results_checked = 0;
   ready_mode_type     ready_mode = READY_ALWAYS;
   int                 ready_left = 0;

   value_noise_3d_unit #(.FRAC_BITS(FRAC_BITS)) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_x_coord     (req_x_coord),
      .req_y_coord     (req_y_coord),
      .req_z_coord     (req_z_coord),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_noise_value (rsp_noise_value),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_hash_salt   (csr_hash_salt)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] scramble32(logic [31:0] v);
      v = v ^ (v >> 16);
      v = v * SCRAMBLE_M1;
      v = v ^ (v >> 15);
      v = v * SCRAMBLE_M2;
      v = v ^ (v >> 16);
      return v;
   endfunction

   function automatic logic [VALUE_W-1:0] lattice_value(logic [31:0] cx, logic [31:0] cy,
                                                        logic [31:0] cz);
      logic [31:0] h;
      h = (cx * CELL_MUL_X) ^ (cy * CELL_MUL_Y) ^ (cz * CELL_MUL_Z);
      h = scramble32(h);
      h = scramble32(h ^ salt_shadow);
      return h[31:8];
   endfunction

   function automatic logic [WORD_W-1:0] lattice_cell(logic [WORD_W-1:0] raw);
      return $signed(raw) >>> FRAC_BITS;
   endfunction

   function automatic logic [31:0] fade_weight(logic [WORD_W-1:0] raw);
      logic [63:0] f;
      logic [63:0] s;
      logic [63:0] w;
      f = {32'd0, raw} & ((64'd1 << FRAC_BITS) - 64'd1);
      s = (f * f) >> FRAC_BITS;
      w = (s * ((64'd3 << FRAC_BITS) - 64'd2 * f)) >> FRAC_BITS;
      return w[31:0];
   endfunction

   function automatic logic [VALUE_W-1:0] blend_q24(logic [VALUE_W-1:0] a,
                                                    logic [VALUE_W-1:0] b, logic [31:0] t);
      longint diff;
      longint prod;
      longint sum;
      diff = longint'({40'd0, b}) - longint'({40'd0, a});
      prod = diff * longint'({32'd0, t});
      sum  = longint'({40'd0, a}) + (prod >>> FRAC_BITS);
      return sum[VALUE_W-1:0];
   endfunction

   function automatic logic [VALUE_W-1:0] predict_noise(logic [WORD_W-1:0] x,
                                                        logic [WORD_W-1:0] y,
                                                        logic [WORD_W-1:0] z);
      logic [31:0]        bx, by, bz, tx, ty, tz;
      logic [VALUE_W-1:0] corner[8];
      logic [VALUE_W-1:0] x00, x10, x01, x11, y0, y1;
      bx = lattice_cell(x);
      by = lattice_cell(y);
      bz = lattice_cell(z);
      tx = fade_weight(x);
      ty = fade_weight(y);
      tz = fade_weight(z);
      for (int k = 0; k < 8; k++) begin
         corner[k] = lattice_value(bx + 32'(k & 1), by + 32'((k >> 1) & 1), bz + 32'(k >> 2));
      end
      x00 = blend_q24(corner[0], corner[1], tx);
      x10 = blend_q24(corner[2], corner[3], tx);
      x01 = blend_q24(corner[4], corner[5], tx);
      x11 = blend_q24(corner[6], corner[7], tx);
      y0  = blend_q24(x00, x10, ty);
      y1  = blend_q24(x01, x11, ty);
      return blend_q24(y0, y1, tz);
   endfunction

   function automatic logic [WORD_W-1:0] random_coord();
      logic [WORD_W-1:0] v;
      logic [15:0]       hi;
      v = $urandom;
      case ($urandom_range(0, 3))
         0: begin
            hi = 16'($urandom_range(0, 16));
            v[31:16] = hi - 16'd8;
         end
         1: begin
            case ($urandom_range(0, 3))
               0: v[15:0] = 16'h0000;
               1: v[15:0] = 16'hffff;
               2: v[15:0] = 16'h8000;
               default: v[15:0] = 16'h0001;
            endcase
            if ($urandom_range(0, 1) == 1) begin
               case ($urandom_range(0, 3))
                  0: v[31:16] = 16'h8000;
                  1: v[31:16] = 16'h7fff;
                  2: v[31:16] = 16'hffff;
                  default: v[31:16] = 16'h0000;
               endcase
            end
         end
         default: ;
      endcase
      return v;
   endfunction

   // receiver: stall pattern in epochs of random mode and length
   always @(posedge clock) begin
      if (ready_left == 0) begin
         ready_mode <= ready_mode_type'($urandom_range(0, 3));
         ready_left <= $urandom_range(8, 48);
      end else begin
         ready_left <= ready_left - 1;
      end
      case (ready_mode)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_HALF:   rsp_ready <= ($urandom_range(0, 1) == 1);
         READY_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:      rsp_ready <= 1'b0;
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_noise.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, expected none, actual %h", $time, rsp_noise_value);
         end else begin
            noise_want = expected_noise.pop_front();
            results_checked++;
            if (rsp_noise_value !== noise_want) begin
               errors++;
               $display("%0t: noise_value mismatch, expected %h, actual %h",
                        $time, noise_want, rsp_noise_value);
            end
         end
      end
   end

   task automatic send_point(logic [WORD_W-1:0] x, logic [WORD_W-1:0] y, logic [WORD_W-1:0] z);
      req_valid   <= 1'b1;
      req_x_coord <= x;
      req_y_coord <= y;
      req_z_coord <= z;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_noise = {expected_noise, predict_noise(x, y, z)};
      points_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_noise.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_salt(logic [WORD_W-1:0] salt);
      drain_results();
      csr_valid     <= 1'b1;
      csr_hash_salt <= salt;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      salt_shadow = salt;
      salt_writes++;
      csr_valid <= 1'b0;
   endtask

   task automatic send_random(int count);
      int left;
      int burst;
      int gap;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 24);
         if (burst > left) burst = left;
         repeat (burst) send_point(random_coord(), random_coord(), random_coord());
         left -= burst;
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic test_default_salt();
      send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_point(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      send_point(32'h0000_ffff, 32'h0001_0000, 32'h0000_8000);
      send_point(32'hffff_0000, 32'h0000_0001, 32'hffff_fffe);
      send_point(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000);
      send_point(32'h1234_5678, 32'h9abc_def0, 32'h0f0f_0f0f);
   endtask

   task automatic test_salt_extremes();
      write_salt(32'h0000_0000);
      send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
      send_point(32'h0003_c000, 32'hfffd_4000, 32'h0000_7fff);
      write_salt(32'hffff_ffff);
      send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0000_ffff);
      send_point(32'hfffe_8001, 32'h0002_fffe, 32'h5555_aaaa);
   endtask

   task automatic test_drain_pause();
      write_salt(DEFAULT_SALT);
      send_random(20);
      drain_results();
      send_random(20);
   endtask

   task automatic test_random_points();
      for (int phase = 0; phase < 4; phase++) begin
         write_salt($urandom);
         send_random(90);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_salt();
      test_salt_extremes();
      test_drain_pause();
      test_random_points();
      drain_results();
      $display("Checked %0d noise words from %0d points across %0d salt settings.",
               results_checked, points_sent, salt_writes + 1);
      $display("Covered coordinate extremes, lattice boundaries and receiver stalls.");
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d words outstanding.", expected_noise.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule
